// ----- design/lmcf_pkg.sv -----
// ----------------------------------------------------------------------------
// lmcf_pkg
// Shared types and constants for the letter multiset containment filter.
// ----------------------------------------------------------------------------
package lmcf_pkg;

    localparam int LETTERS = 26;
    localparam int SLOT_W  = 5;

    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;

    localparam int COUNT_WIDTH_DEFAULT = 8;
    localparam int INDEX_WIDTH_DEFAULT = 16;
    localparam int WORD_INDEX_W        = 16;
    localparam int CHAR_W              = 8;
    localparam int M_TDATA_W           = 24;

    localparam logic OP_RACK = 1'b0;
    localparam logic OP_WORD = 1'b1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    // one classified character word between front and back
    typedef struct packed {
        logic              op;
        logic              letter;
        logic [SLOT_W-1:0] slot;
        logic              last;
    } item_t;

endpackage

// ----- design/lmcf_front.sv -----
// ----------------------------------------------------------------------------
// lmcf_front
// Classifies an incoming character: letter or not, case-folded letter slot.
// ----------------------------------------------------------------------------
module lmcf_front (
    input  logic                        op,
    input  logic [lmcf_pkg::CHAR_W-1:0] ch,
    input  logic                        last,
    output lmcf_pkg::item_t             item
);

    logic                        is_lower;
    logic                        is_upper;
    logic [lmcf_pkg::CHAR_W-1:0] offset;

    assign is_lower = (ch >= lmcf_pkg::CHAR_LOWER_A) && (ch <= lmcf_pkg::CHAR_LOWER_Z);
    assign is_upper = (ch >= lmcf_pkg::CHAR_UPPER_A) && (ch <= lmcf_pkg::CHAR_UPPER_Z);

    // fold case by subtracting the matching base letter
    assign offset = is_lower ? (ch - lmcf_pkg::CHAR_LOWER_A) : (ch - lmcf_pkg::CHAR_UPPER_A);

    always_comb begin
        item.op     = op;
        item.letter = is_lower || is_upper;
        item.slot   = offset[lmcf_pkg::SLOT_W-1:0];
        item.last   = last;
    end

endmodule

// ----- design/lmcf_queue.sv -----
// ----------------------------------------------------------------------------
// lmcf_queue
// Short show-ahead queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module lmcf_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  lmcf_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output lmcf_pkg::item_t head_item
);

    lmcf_pkg::item_t                     mem_reg [lmcf_pkg::QUEUE_DEPTH];
    logic [lmcf_pkg::QUEUE_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [lmcf_pkg::QUEUE_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [lmcf_pkg::QUEUE_PTR_W:0]      count_reg, count_next;

    localparam logic [lmcf_pkg::QUEUE_PTR_W:0] DEPTH_COUNT =
        (lmcf_pkg::QUEUE_PTR_W+1)'(lmcf_pkg::QUEUE_DEPTH);

    assign full      = (count_reg == DEPTH_COUNT);
    assign not_empty = (count_reg != '0);
    assign head_item = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- design/lmcf_back.sv -----
// ----------------------------------------------------------------------------
// lmcf_back
// Keeps the rack and word letter histograms, runs the 26-lane containment
// check at each word end and holds the result in an output register.
// ----------------------------------------------------------------------------
module lmcf_back #(
    parameter int COUNT_WIDTH = lmcf_pkg::COUNT_WIDTH_DEFAULT,
    parameter int INDEX_WIDTH = lmcf_pkg::INDEX_WIDTH_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    input  lmcf_pkg::item_t                   in_item,
    output logic                              in_pop,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              out_fits,
    output logic [lmcf_pkg::WORD_INDEX_W-1:0] out_index
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [INDEX_WIDTH-1:0] INDEX_MAX = {INDEX_WIDTH{1'b1}};

    logic [COUNT_WIDTH-1:0] rack_reg [lmcf_pkg::LETTERS];
    logic [COUNT_WIDTH-1:0] rack_next [lmcf_pkg::LETTERS];
    logic [COUNT_WIDTH-1:0] word_reg [lmcf_pkg::LETTERS];
    logic [COUNT_WIDTH-1:0] word_next [lmcf_pkg::LETTERS];
    logic [COUNT_WIDTH-1:0] word_bumped [lmcf_pkg::LETTERS];
    logic [COUNT_WIDTH-1:0] rack_base;
    logic [lmcf_pkg::LETTERS-1:0] lane_fail;
    logic [lmcf_pkg::LETTERS-1:0] hit;

    logic [INDEX_WIDTH-1:0] counter_reg, counter_next;
    logic                   closed_reg, closed_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   fits_reg;
    logic [lmcf_pkg::WORD_INDEX_W-1:0] index_reg;
    logic [lmcf_pkg::WORD_INDEX_W-1:0] index_low;

    logic produces;
    logic rack_op;

    assign rack_op  = (in_item.op == lmcf_pkg::OP_RACK);
    assign produces = (in_item.op == lmcf_pkg::OP_WORD) && in_item.last;
    // advance unless a result must wait for the output register
    assign in_pop   = in_valid && (!produces || !out_valid_reg || out_ready);

    generate
        if (INDEX_WIDTH >= lmcf_pkg::WORD_INDEX_W) begin : g_idx_trunc
            assign index_low = counter_reg[lmcf_pkg::WORD_INDEX_W-1:0];
        end else begin : g_idx_ext
            assign index_low = {{(lmcf_pkg::WORD_INDEX_W-INDEX_WIDTH){1'b0}}, counter_reg};
        end
    endgenerate

    always_comb begin
        for (int i = 0; i < lmcf_pkg::LETTERS; i++) begin
            hit[i] = in_item.letter && (in_item.slot == lmcf_pkg::SLOT_W'(i));
        end

        for (int i = 0; i < lmcf_pkg::LETTERS; i++) begin
            rack_base = (rack_op && closed_reg) ? '0 : rack_reg[i];
            rack_next[i] = rack_reg[i];
            word_next[i] = word_reg[i];

            word_bumped[i] = (hit[i] && word_reg[i] != COUNT_MAX) ?
                             word_reg[i] + 1'b1 : word_reg[i];
            lane_fail[i] = (rack_reg[i] != COUNT_MAX) && (word_bumped[i] > rack_reg[i]);

            if (in_pop) begin
                if (rack_op) begin
                    rack_next[i] = (hit[i] && rack_base != COUNT_MAX) ?
                                   rack_base + 1'b1 : rack_base;
                end else begin
                    word_next[i] = in_item.last ? '0 : word_bumped[i];
                end
            end
        end

        counter_next   = counter_reg;
        closed_next    = closed_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (in_pop) begin
            if (rack_op) begin
                if (closed_reg) begin
                    counter_next = '0;
                end
                closed_next = in_item.last;
            end else if (in_item.last) begin
                out_valid_next = 1'b1;
                if (counter_reg != INDEX_MAX) begin
                    counter_next = counter_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < lmcf_pkg::LETTERS; i++) begin
                rack_reg[i] <= '0;
                word_reg[i] <= '0;
            end
            counter_reg   <= '0;
            closed_reg    <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            for (int i = 0; i < lmcf_pkg::LETTERS; i++) begin
                rack_reg[i] <= rack_next[i];
                word_reg[i] <= word_next[i];
            end
            counter_reg   <= counter_next;
            closed_reg    <= closed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload; loaded only when a word ends
    always_ff @(posedge aclk) begin
        if (in_pop && produces) begin
            fits_reg  <= ~|lane_fail;
            index_reg <= index_low;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_fits  = fits_reg;
    assign out_index = index_reg;

endmodule

// ----- design/letter_multiset_containment_filter_core.sv -----
// Output: a word's result is registered in the back end and held until it is taken.
// Throughput: one character per cycle unless the queue is full; the back end updates
// one 26-lane histogram and runs the 26-way compare; a four-entry queue absorbs stalls.
// Reset: synchronous, active low; clears histograms, word index and queue, and marks
// the rack closed so that the next rack character starts a fresh rack.
// ----------------------------------------------------------------------------
// letter_multiset_containment_filter_core
// Streams rack and word characters and reports, per word, whether the word's
// letters fit within the rack's letters, along with the word's index.
// ----------------------------------------------------------------------------
module letter_multiset_containment_filter_core #(
    parameter int COUNT_WIDTH = lmcf_pkg::COUNT_WIDTH_DEFAULT,
    parameter int INDEX_WIDTH = lmcf_pkg::INDEX_WIDTH_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [lmcf_pkg::CHAR_W-1:0]    s_tdata,   // [7:0] ch
    input  logic                           s_tuser,   // [0] operation
    input  logic                           s_tlast,   // last
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [lmcf_pkg::M_TDATA_W-1:0] m_tdata    // [0] fits, [16:1] word_index
);

    lmcf_pkg::item_t front_item;
    lmcf_pkg::item_t head_item;
    logic            queue_full;
    logic            queue_not_empty;
    logic            queue_pop;
    logic            fits;
    logic [lmcf_pkg::WORD_INDEX_W-1:0] word_index;

    lmcf_front u_front (
        .op   (s_tuser),
        .ch   (s_tdata),
        .last (s_tlast),
        .item (front_item)
    );

    assign s_tready = !queue_full;

    lmcf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_tvalid && !queue_full),
        .push_item (front_item),
        .full      (queue_full),
        .pop       (queue_pop),
        .not_empty (queue_not_empty),
        .head_item (head_item)
    );

    lmcf_back #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (queue_not_empty),
        .in_item   (head_item),
        .in_pop    (queue_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_fits  (fits),
        .out_index (word_index)
    );

    assign m_tdata = {{(lmcf_pkg::M_TDATA_W - lmcf_pkg::WORD_INDEX_W - 1){1'b0}},
                      word_index, fits};

endmodule

// ----- tb/letter_multiset_containment_filter_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// letter_multiset_containment_filter_core_tb
// Streams rack and dictionary-word characters into the filter. The testbench
// keeps its own rack and word letter histograms to work out each word's
// fit verdict and index, and checks every result word against them in order.
// It covers directed corner cases, count saturation, random racks and words
// with noise, and back-pressure.
// ----------------------------------------------------------------------------
module letter_multiset_containment_filter_core_tb;

    localparam int CNT_W   = lmcf_pkg::COUNT_WIDTH_DEFAULT;
    localparam int IDX_W   = lmcf_pkg::INDEX_WIDTH_DEFAULT;
    localparam int CH_W    = lmcf_pkg::CHAR_W;
    localparam int IX_W    = lmcf_pkg::WORD_INDEX_W;
    localparam int MD_W    = lmcf_pkg::M_TDATA_W;
    localparam int NLET    = lmcf_pkg::LETTERS;
    localparam logic [CNT_W-1:0] CNT_TOP = '1;
    localparam logic [IDX_W-1:0] IDX_TOP = '1;

    typedef struct {
        bit                pause;   // wait for all verdicts before going on
        bit                op;
        bit [CH_W-1:0]     ch;
        bit                last;
    } stim_char_t;

    typedef struct {
        bit              fits;
        bit [IX_W-1:0]   idx;
    } verdict_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [CH_W-1:0]      s_tdata  = '0;
    logic                 s_tuser  = 1'b0;
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [MD_W-1:0]      m_tdata;

    stim_char_t char_queue[$];
    verdict_t   expected_verdicts[$];
    int         verdicts_pending = 0;
    int         chars_taken      = 0;
    int         chars_queued     = 0;
    int         mismatches       = 0;
    int         random_base      = 1 << 30;
    logic       calm;

    // predictor state
    logic [CNT_W-1:0] rack_hist[NLET];
    logic [CNT_W-1:0] word_hist[NLET];
    logic [IDX_W-1:0] word_idx;
    bit               rack_done;

    int  hold_cycles = 0;
    bit  hold_done   = 1'b0;

    letter_multiset_containment_filter_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    assign calm = (chars_taken >= random_base + 70) && (chars_taken < random_base + 130);

    function automatic int alpha_slot(input bit [CH_W-1:0] c);
        if (c >= lmcf_pkg::CHAR_LOWER_A && c <= lmcf_pkg::CHAR_LOWER_Z)
            return int'(c - lmcf_pkg::CHAR_LOWER_A);
        if (c >= lmcf_pkg::CHAR_UPPER_A && c <= lmcf_pkg::CHAR_UPPER_Z)
            return int'(c - lmcf_pkg::CHAR_UPPER_A);
        return -1;
    endfunction

    function automatic bit [CH_W-1:0] letter_byte(input int slot, input bit upper);
        return (upper ? lmcf_pkg::CHAR_UPPER_A : lmcf_pkg::CHAR_LOWER_A) + CH_W'(slot);
    endfunction

    task automatic push_char(input bit op, input bit [CH_W-1:0] ch, input bit last);
        stim_char_t c;
        c.pause = 1'b0;
        c.op    = op;
        c.ch    = ch;
        c.last  = last;
        char_queue.push_back(c);
        chars_queued++;
    endtask

    task automatic push_pause();
        stim_char_t c;
        c = '{pause: 1'b1, op: 1'b0, ch: '0, last: 1'b0};
        char_queue.push_back(c);
    endtask

    task automatic push_text(input bit op, input string s);
        for (int i = 0; i < s.len(); i++)
            push_char(op, s[i], i == s.len() - 1);
    endtask

    task automatic predict_char(input bit op, input bit [CH_W-1:0] ch, input bit last);
        int       s;
        bit       ok;
        verdict_t v;
        s = alpha_slot(ch);
        if (op == lmcf_pkg::OP_RACK) begin
            if (rack_done) begin
                foreach (rack_hist[i]) rack_hist[i] = '0;
                word_idx  = '0;
                rack_done = 1'b0;
            end
            if (s >= 0 && rack_hist[s] != CNT_TOP)
                rack_hist[s] = rack_hist[s] + 1'b1;
            if (last)
                rack_done = 1'b1;
        end else begin
            if (s >= 0 && word_hist[s] != CNT_TOP)
                word_hist[s] = word_hist[s] + 1'b1;
            if (last) begin
                ok = 1'b1;
                foreach (rack_hist[i])
                    if (rack_hist[i] != CNT_TOP && word_hist[i] > rack_hist[i])
                        ok = 1'b0;
                v.fits = ok;
                v.idx  = word_idx[IX_W-1:0];
                expected_verdicts.push_back(v);
                foreach (word_hist[i]) word_hist[i] = '0;
                if (word_idx != IDX_TOP)
                    word_idx = word_idx + 1'b1;
            end
        end
    endtask

    // driver: present the next character once the current character is taken
    always @(posedge aclk) begin : drive_chars
        stim_char_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (char_queue.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (char_queue[0].pause) begin
                if (!s_tvalid && verdicts_pending == 0)
                    void'(char_queue.pop_front());
                s_tvalid <= 1'b0;
            end else if (!calm && $urandom_range(0, 99) < 8) begin
                s_tvalid <= 1'b0;
            end else begin
                nxt = char_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= nxt.ch;
                s_tuser  <= nxt.op;
                s_tlast  <= nxt.last;
            end
        end
    end

    // receiver: one long hold-off early in the random part, else random stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (!hold_done && chars_taken >= random_base + 40) begin
            hold_done   <= 1'b1;
            hold_cycles <= 150;
            m_tready    <= 1'b0;
        end else if (hold_cycles != 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready    <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(0, 99) >= 8);
        end
    end

    // monitor: check the outgoing verdict first, then predict the accepted char
    always @(posedge aclk) begin : watch_verdicts
        verdict_t v;
        if (!aresetn) begin
            foreach (rack_hist[i]) rack_hist[i] = '0;
            foreach (word_hist[i]) word_hist[i] = '0;
            word_idx  = '0;
            rack_done = 1'b1;
            verdicts_pending <= 0;
            chars_taken      <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_verdicts.size() == 0) begin
                    $error("unexpected result word: m_tdata=%h", m_tdata);
                    mismatches++;
                end else begin
                    v = expected_verdicts.pop_front();
                    if (m_tdata[0] !== v.fits) begin
                        $error("fits: expected %0d, got %0d", v.fits, m_tdata[0]);
                        mismatches++;
                    end
                    if (m_tdata[16:1] !== v.idx) begin
                        $error("word_index: expected %0d, got %0d", v.idx, m_tdata[16:1]);
                        mismatches++;
                    end
                    if (m_tdata[MD_W-1:17] !== '0) begin
                        $error("pad: expected 0, got %h", m_tdata[MD_W-1:17]);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                predict_char(s_tuser, s_tdata, s_tlast);
                chars_taken <= chars_taken + 1;
            end
            verdicts_pending <= expected_verdicts.size();
        end
    end

    initial begin : stimulus
        bit [CH_W-1:0] b;
        int rack_letters[$];
        int rlen;
        int nwords;
        int wlen;
        int s;
        bit paused_mid;

        // word before any rack: everything empty, cannot fit
        push_char(lmcf_pkg::OP_WORD, "a", 1'b1);
        // rack closed by a non-letter
        push_text(lmcf_pkg::OP_RACK, "Ab#");
        push_text(lmcf_pkg::OP_WORD, "bA");
        push_text(lmcf_pkg::OP_WORD, "aa");
        push_char(lmcf_pkg::OP_WORD, "@", 1'b1);
        // bytes around the letter ranges, all ignored
        push_char(lmcf_pkg::OP_WORD, 8'h00, 1'b0);
        push_char(lmcf_pkg::OP_WORD, 8'hff, 1'b0);
        push_char(lmcf_pkg::OP_WORD, 8'h60, 1'b0);
        push_char(lmcf_pkg::OP_WORD, 8'h7b, 1'b0);
        push_char(lmcf_pkg::OP_WORD, 8'h40, 1'b0);
        push_char(lmcf_pkg::OP_WORD, 8'h5b, 1'b1);
        push_text(lmcf_pkg::OP_WORD, "Zz");
        // unfinished word carries into the word after a new rack
        push_char(lmcf_pkg::OP_WORD, "z", 1'b0);
        push_char(lmcf_pkg::OP_RACK, "z", 1'b1);
        push_char(lmcf_pkg::OP_WORD, "z", 1'b1);
        // words compared against a rack still open
        push_char(lmcf_pkg::OP_RACK, "c", 1'b0);
        push_char(lmcf_pkg::OP_WORD, "C", 1'b1);
        push_char(lmcf_pkg::OP_RACK, "d", 1'b1);
        push_text(lmcf_pkg::OP_WORD, "cD");
        push_pause();

        // rack letter count held at its top value instead of wrapping to zero
        for (int i = 0; i < 256; i++)
            push_char(lmcf_pkg::OP_RACK, (i % 2) ? "E" : "e", 1'b0);
        push_char(lmcf_pkg::OP_RACK, "m", 1'b1);
        push_text(lmcf_pkg::OP_WORD, "eEm");
        push_pause();

        // random racks and words, with some noise
        random_base = chars_queued;
        paused_mid  = 1'b0;
        while (chars_queued < random_base + 165) begin
            if ($urandom_range(0, 9) < 7) begin
                rack_letters.delete();
                rlen = $urandom_range(1, 10);
                for (int i = 0; i < rlen; i++) begin
                    if ($urandom_range(0, 7) == 0) begin
                        b = CH_W'($urandom_range(0, 255));
                    end else begin
                        s = $urandom_range(0, NLET - 1);
                        rack_letters.push_back(s);
                        b = letter_byte(s, 1'($urandom_range(0, 1)));
                    end
                    // leave the rack open now and then
                    push_char(lmcf_pkg::OP_RACK, b,
                              (i == rlen - 1) && ($urandom_range(0, 9) != 0));
                end
                nwords = $urandom_range(1, 6);
                for (int w = 0; w < nwords; w++) begin
                    wlen = $urandom_range(1, 7);
                    for (int i = 0; i < wlen; i++) begin
                        if (rack_letters.size() != 0 && $urandom_range(0, 2) != 0)
                            s = rack_letters[$urandom_range(0, rack_letters.size() - 1)];
                        else
                            s = $urandom_range(0, NLET - 1);
                        push_char(lmcf_pkg::OP_WORD, letter_byte(s, 1'($urandom_range(0, 1))),
                                  i == wlen - 1);
                    end
                end
            end else begin
                repeat ($urandom_range(1, 6))
                    push_char(1'($urandom_range(0, 1)), CH_W'($urandom_range(0, 255)),
                              $urandom_range(0, 2) == 0);
            end
            if (!paused_mid && chars_queued >= random_base + 110) begin
                push_pause();
                paused_mid = 1'b1;
            end
        end
        push_pause();

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        while (char_queue.size() != 0 || s_tvalid || verdicts_pending != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (mismatches == 0 && expected_verdicts.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
